// ===== sv/fvs_pkg.sv =====
// Package for the frame victim selector: codes, register indexes, state types
// and the word formats passed between the sequencer and the frame table.
// Depends on nothing; every other file uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fvs_pkg;

  // Default frame table depth.
  localparam int unsigned MaxFramesDef = 64;

  // Fixed field widths of the ports.
  localparam int unsigned IdxPortW   = 6;
  localparam int unsigned CoinW      = 64;
  localparam int unsigned FramesCfgW = 7;
  localparam int unsigned CfgDataW   = 7;
  localparam int unsigned PolicyW    = 2;

  // Reset value of the frame count register.
  localparam logic [FramesCfgW-1:0] FramesReset = 7'd64;

  // Commands carried by an input word.
  typedef enum logic [1:0] {
    CMD_VICTIM      = 2'd0,
    CMD_REFERENCE   = 2'd1,
    CMD_WRITE_FLAGS = 2'd2
  } cmd_e;

  // Outcome codes of a victim request.
  typedef enum logic [1:0] {
    OUT_FREE     = 2'd0,
    OUT_EVICT    = 2'd1,
    OUT_ALL_PROT = 2'd2
  } outcome_e;

  // Victim policies.
  typedef enum logic [PolicyW-1:0] {
    POL_RANDOM = 2'd0,
    POL_FIFO   = 2'd1,
    POL_CLOCK  = 2'd2
  } policy_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_POLICY = 1'b0,
    REG_FRAMES = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE,
    ST_MOD,
    ST_RANDOM,
    ST_FIFO,
    ST_CLOCK
  } state_e;

  // Frame table write operations.
  typedef enum logic [2:0] {
    TBL_NOP,
    TBL_SET_REF,
    TBL_WRITE,
    TBL_CLR_REF,
    TBL_CLR_MAP,
    TBL_CLEAR
  } tbl_op_e;

  // Write request to the frame table.
  typedef struct packed {
    tbl_op_e op;
    logic    map_val;
    logic    prot_val;
  } tbl_wr_t;

  // Flags of one frame as read from the table.
  typedef struct packed {
    logic mapped;
    logic prot;
    logic refd;
  } tbl_rd_t;

endpackage

`default_nettype wire

// ===== sv/fvs_frame_table.sv =====
// Frame flag table: mapped, protected and referenced bits for every frame,
// one registered read port and one write operation per cycle. Uses fvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fvs_frame_table #(
  parameter int unsigned MaxFrames = fvs_pkg::MaxFramesDef,
  parameter int unsigned FrameW    = $clog2(MaxFrames)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fvs_pkg::tbl_wr_t  wr_i,
  input  wire logic [FrameW-1:0] wr_idx_i,
  input  wire logic [FrameW-1:0] rd_idx_i,
  output fvs_pkg::tbl_rd_t       rd_o
);

  logic             mapped_mem [MaxFrames];
  logic             prot_mem   [MaxFrames];
  logic             refd_mem   [MaxFrames];
  logic             map_we;
  logic             prot_we;
  logic             refd_we;
  logic             map_wval;
  logic             prot_wval;
  logic             refd_wval;
  logic             same_idx;
  fvs_pkg::tbl_rd_t rd_q;

  // Decode the write operation into per-flag enables and values.
  always_comb begin
    map_we    = 1'b0;
    prot_we   = 1'b0;
    refd_we   = 1'b0;
    map_wval  = 1'b0;
    prot_wval = 1'b0;
    refd_wval = 1'b0;
    case (wr_i.op)
      fvs_pkg::TBL_SET_REF: begin
        refd_we   = 1'b1;
        refd_wval = 1'b1;
      end
      fvs_pkg::TBL_WRITE: begin
        map_we    = 1'b1;
        map_wval  = wr_i.map_val;
        prot_we   = 1'b1;
        prot_wval = wr_i.prot_val;
      end
      fvs_pkg::TBL_CLR_REF: begin
        refd_we = 1'b1;
      end
      fvs_pkg::TBL_CLR_MAP: begin
        map_we = 1'b1;
      end
      fvs_pkg::TBL_CLEAR: begin
        map_we  = 1'b1;
        prot_we = 1'b1;
        refd_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Flag memories, one write address per cycle.
  always_ff @(posedge clk_i) begin
    if (map_we)  mapped_mem[wr_idx_i] <= map_wval;
    if (prot_we) prot_mem[wr_idx_i]   <= prot_wval;
    if (refd_we) refd_mem[wr_idx_i]   <= refd_wval;
  end

  // Registered read; a write to the same frame in the same cycle is passed on.
  assign same_idx = (wr_idx_i == rd_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
    end else begin
      rd_q.mapped <= (map_we && same_idx) ? map_wval : mapped_mem[rd_idx_i];
      rd_q.prot   <= (prot_we && same_idx) ? prot_wval : prot_mem[rd_idx_i];
      rd_q.refd   <= (refd_we && same_idx) ? refd_wval : refd_mem[rd_idx_i];
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// ===== sv/frame_victim_selector_unit.sv =====
// Top level of the frame victim selector: command port, configuration
// registers and the scan sequencer. Uses fvs_pkg and fvs_frame_table.
//
//   Port group   Direction  Handshake            Content
//   command      in         start_i / busy_o     command, frame, flags, coins
//   result       out        done_o (one cycle)   victim_frame_o, outcome_o
//   config       in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// Update commands finish in the cycle they are taken; busy_o stays low.
// A victim request examines one frame per cycle while scanning, through a single
// compare path: first the free-frame scan, then for fifo and clock a reduction
// of the hand modulo the frame count, then at most one round of the frames
// (random, fifo) or two rounds (clock), with done_o in the cycle after the last step.
// After reset a clearing pass zeroes one frame per cycle, through all MaxFrames
// frames, with busy_o high; the hand and the registers reset at once.
// Results are shown for one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module frame_victim_selector_unit #(
  parameter int unsigned MaxFrames = fvs_pkg::MaxFramesDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [1:0]                       command_i,
  input  wire logic [fvs_pkg::IdxPortW-1:0]     frame_index_i,
  input  wire logic                             mapped_value_i,
  input  wire logic                             protected_value_i,
  input  wire logic [fvs_pkg::CoinW-1:0]        coin_bits_i,
  output logic                                  done_o,
  output logic [fvs_pkg::IdxPortW-1:0]          victim_frame_o,
  output logic [1:0]                            outcome_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [0:0]                       cfg_idx_i,
  input  wire logic [fvs_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int unsigned FrameW  = $clog2(MaxFrames);
  localparam int unsigned CntW    = FrameW + 1;
  localparam int unsigned StepW   = FrameW + 2;
  localparam int unsigned VictimW = fvs_pkg::IdxPortW;

  fvs_pkg::state_e                    state_q, state_d;
  logic [FrameW-1:0]                  f_q, f_d;
  logic [StepW-1:0]                   step_q, step_d;
  logic [FrameW-1:0]                  hand_q, hand_d;
  logic [fvs_pkg::CoinW-1:0]          coin_q, coin_d;
  logic                               seen_q, seen_d;
  logic [FrameW-1:0]                  last_q, last_d;
  logic                               done_q, done_d;
  logic [VictimW-1:0]                 victim_q, victim_d;
  fvs_pkg::outcome_e                  outcome_q, outcome_d;
  logic [fvs_pkg::PolicyW-1:0]        policy_q;
  logic [fvs_pkg::FramesCfgW-1:0]     frames_q;

  logic [CntW-1:0]                    n;
  logic [FrameW-1:0]                  f_inc;
  logic [StepW-1:0]                   limit;
  logic                               last_step;
  logic                               accept;
  logic                               upd_ok;
  logic                               fin;
  logic                               fin_clr;
  logic [FrameW-1:0]                  fin_idx;
  fvs_pkg::outcome_e                  fin_out;
  fvs_pkg::tbl_wr_t                   tbl_wr;
  logic [FrameW-1:0]                  tbl_wr_idx;
  fvs_pkg::tbl_rd_t                   tbl_rd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= fvs_pkg::POL_RANDOM;
      frames_q <= fvs_pkg::FramesReset;
    end else if (cfg_we_i) begin
      case (fvs_pkg::cfg_reg_e'(cfg_idx_i))
        fvs_pkg::REG_POLICY: policy_q <= cfg_wdata_i[fvs_pkg::PolicyW-1:0];
        fvs_pkg::REG_FRAMES: frames_q <= cfg_wdata_i[fvs_pkg::FramesCfgW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame count clamped to the table depth, at least one.
  always_comb begin
    if (frames_q == '0) begin
      n = CntW'(1);
    end else if (32'(frames_q) > MaxFrames) begin
      n = CntW'(MaxFrames);
    end else begin
      n = CntW'(frames_q);
    end
  end

  // Scan pointer advance with wrap at the frame count, and the step limit.
  assign f_inc     = ((CntW'({1'b0, f_q}) + CntW'(1)) == n) ? '0 : f_q + FrameW'(1);
  assign limit     = (state_q == fvs_pkg::ST_CLOCK) ? {n, 1'b0} : StepW'(n);
  assign last_step = ((step_q + StepW'(1)) == limit);

  assign busy_o = (state_q != fvs_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;
  assign upd_ok = (32'(frame_index_i) < MaxFrames);

  // Sequencer: next state, table writes and result capture.
  always_comb begin
    state_d    = state_q;
    f_d        = f_q;
    step_d     = step_q;
    hand_d     = hand_q;
    coin_d     = coin_q;
    seen_d     = seen_q;
    last_d     = last_q;
    done_d     = 1'b0;
    victim_d   = victim_q;
    outcome_d  = outcome_q;
    fin        = 1'b0;
    fin_clr    = 1'b0;
    fin_idx    = '0;
    fin_out    = fvs_pkg::OUT_ALL_PROT;
    tbl_wr     = '{op: fvs_pkg::TBL_NOP, map_val: mapped_value_i,
                   prot_val: protected_value_i};
    tbl_wr_idx = f_q;

    case (state_q)
      // Zero the flags of one frame per cycle after reset.
      fvs_pkg::ST_CLEAR: begin
        tbl_wr.op = fvs_pkg::TBL_CLEAR;
        if (32'(f_q) == MaxFrames - 1) begin
          state_d = fvs_pkg::ST_IDLE;
        end else begin
          f_d = f_q + FrameW'(1);
        end
      end

      fvs_pkg::ST_IDLE: begin
        if (accept) begin
          case (fvs_pkg::cmd_e'(command_i))
            fvs_pkg::CMD_VICTIM: begin
              state_d = fvs_pkg::ST_FREE;
              f_d     = '0;
              step_d  = '0;
              coin_d  = coin_bits_i;
            end
            fvs_pkg::CMD_REFERENCE: begin
              tbl_wr_idx = FrameW'(frame_index_i);
              if (upd_ok) tbl_wr.op = fvs_pkg::TBL_SET_REF;
            end
            fvs_pkg::CMD_WRITE_FLAGS: begin
              tbl_wr_idx = FrameW'(frame_index_i);
              if (upd_ok) tbl_wr.op = fvs_pkg::TBL_WRITE;
            end
            default: begin
            end
          endcase
        end
      end

      // Lowest frame that is neither mapped nor protected.
      fvs_pkg::ST_FREE: begin
        if (!tbl_rd.prot && !tbl_rd.mapped) begin
          fin     = 1'b1;
          fin_idx = f_q;
          fin_out = fvs_pkg::OUT_FREE;
        end else if (last_step) begin
          case (policy_q)
            fvs_pkg::POL_RANDOM: begin
              state_d = fvs_pkg::ST_RANDOM;
              f_d     = '0;
              step_d  = '0;
              seen_d  = 1'b0;
              last_d  = '0;
            end
            fvs_pkg::POL_FIFO, fvs_pkg::POL_CLOCK: begin
              state_d = fvs_pkg::ST_MOD;
              f_d     = hand_q;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end else begin
          f_d    = f_inc;
          step_d = step_q + StepW'(1);
        end
      end

      // Reduce the hand modulo the frame count by repeated subtraction.
      fvs_pkg::ST_MOD: begin
        if (CntW'({1'b0, f_q}) >= n) begin
          f_d = f_q - FrameW'(n);
        end else begin
          state_d = (policy_q == fvs_pkg::POL_FIFO) ? fvs_pkg::ST_FIFO
                                                    : fvs_pkg::ST_CLOCK;
          step_d  = '0;
        end
      end

      // First unprotected frame with its coin set, else the last unprotected.
      fvs_pkg::ST_RANDOM: begin
        if (!tbl_rd.prot) begin
          seen_d = 1'b1;
          last_d = f_q;
        end
        if (!tbl_rd.prot && coin_q[0]) begin
          fin     = 1'b1;
          fin_clr = 1'b1;
          fin_idx = f_q;
          fin_out = fvs_pkg::OUT_EVICT;
        end else if (last_step) begin
          fin = 1'b1;
          if (!tbl_rd.prot) begin
            fin_clr = 1'b1;
            fin_idx = f_q;
            fin_out = fvs_pkg::OUT_EVICT;
          end else if (seen_q) begin
            fin_clr = 1'b1;
            fin_idx = last_q;
            fin_out = fvs_pkg::OUT_EVICT;
          end
        end else begin
          f_d    = f_inc;
          step_d = step_q + StepW'(1);
          coin_d = coin_q >> 1;
        end
      end

      // Next unprotected frame from the hand.
      fvs_pkg::ST_FIFO: begin
        if (!tbl_rd.prot) begin
          fin     = 1'b1;
          fin_clr = 1'b1;
          fin_idx = f_q;
          fin_out = fvs_pkg::OUT_EVICT;
          hand_d  = f_inc;
        end else if (last_step) begin
          fin = 1'b1;
        end else begin
          f_d    = f_inc;
          step_d = step_q + StepW'(1);
        end
      end

      // Clock sweep: clear referenced bits until an unreferenced frame.
      fvs_pkg::ST_CLOCK: begin
        if (!tbl_rd.prot && !tbl_rd.refd) begin
          fin     = 1'b1;
          fin_clr = 1'b1;
          fin_idx = f_q;
          fin_out = fvs_pkg::OUT_EVICT;
          hand_d  = f_inc;
        end else begin
          if (!tbl_rd.prot) tbl_wr.op = fvs_pkg::TBL_CLR_REF;
          if (last_step) begin
            fin = 1'b1;
          end else begin
            f_d    = f_inc;
            step_d = step_q + StepW'(1);
          end
        end
      end

      default: begin
        state_d = fvs_pkg::ST_IDLE;
      end
    endcase

    // Finish a victim request: capture the result and release the mapping.
    if (fin) begin
      state_d   = fvs_pkg::ST_IDLE;
      done_d    = 1'b1;
      victim_d  = VictimW'(fin_idx);
      outcome_d = fin_out;
      if (fin_clr) begin
        tbl_wr.op  = fvs_pkg::TBL_CLR_MAP;
        tbl_wr_idx = fin_idx;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fvs_pkg::ST_CLEAR;
      f_q     <= '0;
      hand_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      f_q     <= f_d;
      hand_q  <= hand_d;
      done_q  <= done_d;
    end
  end

  // Scan and result registers.
  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    coin_q    <= coin_d;
    seen_q    <= seen_d;
    last_q    <= last_d;
    victim_q  <= victim_d;
    outcome_q <= outcome_d;
  end

  // The table is addressed with f_d, the value the scan pointer is about to take,
  // so that its registered read shows the flags of the frame under the scan pointer.
  fvs_frame_table #(
    .MaxFrames (MaxFrames),
    .FrameW    (FrameW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .wr_idx_i (tbl_wr_idx),
    .rd_idx_i (f_d),
    .rd_o     (tbl_rd)
  );

  assign done_o         = done_q;
  assign victim_frame_o = victim_q;
  assign outcome_o      = outcome_q;

endmodule

`default_nettype wire

// ===== sv/fvs_checker.sv =====
// Port-level checks for the frame victim selector, bound to the top level.
// Uses fvs_pkg for the command and outcome codes.
`timescale 1ns / 1ps
`default_nettype none

module fvs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic [1:0] command_i,
  input wire logic       done_o,
  input wire logic [5:0] victim_frame_o,
  input wire logic [1:0] outcome_o
);

  // A result word only appears once the scan has ended.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // A victim request starts a scan.
  a_victim_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == fvs_pkg::CMD_VICTIM) |=> busy_o)
    else $error("victim request did not start a scan");

  // Any other command finishes at once and gives no result word.
  a_update_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i != fvs_pkg::CMD_VICTIM) |=> (!busy_o && !done_o))
    else $error("update command caused activity");

  // Outcome code is defined, and all-protected reports frame zero.
  a_outcome_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (outcome_o == fvs_pkg::OUT_FREE || outcome_o == fvs_pkg::OUT_EVICT ||
                (outcome_o == fvs_pkg::OUT_ALL_PROT && victim_frame_o == '0)))
    else $error("bad outcome or frame");

endmodule

bind frame_victim_selector_unit fvs_checker u_fvs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .command_i      (command_i),
  .done_o         (done_o),
  .victim_frame_o (victim_frame_o),
  .outcome_o      (outcome_o)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for frame_victim_selector_unit: a queued command driver, a result
// monitor with a built-in frame table predictor, and a no-progress watchdog.
// Depends on fvs_pkg and the RTL of the frame victim selector only.
`timescale 1ns / 1ps

module tb;

  // Codes that the package enums leave out but the ports can carry.
  localparam logic [1:0] CmdUnused    = 2'd3;
  localparam logic [1:0] PolicyUnused = 2'd3;

  // Drain time covers the worst victim request, padded for the pauses.
  localparam int DrainCycles = 3 * fvs_pkg::MaxFramesDef + 80;
  localparam int StallLimit  = 20 * DrainCycles;
  localparam int NumPhases   = 16;
  localparam int PhaseItems  = 32;

  typedef enum logic [1:0] {
    SK_CMD,
    SK_CFG,
    SK_DRAIN
  } stim_kind_e;

  // One pending entry for the driver: a command word, a register write or a pause.
  typedef struct packed {
    stim_kind_e        kind;
    logic [1:0]        cmd;
    logic [5:0]        idx;
    logic              map_val;
    logic              prot_val;
    logic [63:0]       coins;
    fvs_pkg::cfg_reg_e reg_sel;
    logic [6:0]        wdata;
  } stim_t;

  // Expected result word of one victim request.
  typedef struct packed {
    logic [5:0]        frame;
    fvs_pkg::outcome_e outcome;
  } victim_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        start_i           = 1'b0;
  logic [1:0]  command_i         = 2'd0;
  logic [5:0]  frame_index_i     = 6'd0;
  logic        mapped_value_i    = 1'b0;
  logic        protected_value_i = 1'b0;
  logic [63:0] coin_bits_i       = 64'd0;
  logic        cfg_we_i          = 1'b0;
  logic [0:0]  cfg_idx_i         = 1'b0;
  logic [6:0]  cfg_wdata_i       = 7'd0;
  logic        busy_o;
  logic        done_o;
  logic [5:0]  victim_frame_o;
  logic [1:0]  outcome_o;

  stim_t   stim_q[$];
  victim_t owed_victims[$];

  // Driver bookkeeping.
  int results_owed = 0;
  int quiet_cycles = 0;
  int burst_left   = 1;
  int gap_left     = 0;

  // Monitor bookkeeping.
  int errors      = 0;
  int idle_cycles = 0;
  bit stalled     = 1'b0;

  // Predicted frame table, hand and registers.
  bit          frame_mapped[fvs_pkg::MaxFramesDef];
  bit          frame_prot[fvs_pkg::MaxFramesDef];
  bit          frame_refd[fvs_pkg::MaxFramesDef];
  int unsigned sweep_hand = 0;
  logic [1:0]  mode_reg   = fvs_pkg::POL_RANDOM;
  logic [6:0]  frames_reg = fvs_pkg::FramesReset;

  frame_victim_selector_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .frame_index_i    (frame_index_i),
    .mapped_value_i   (mapped_value_i),
    .protected_value_i(protected_value_i),
    .coin_bits_i      (coin_bits_i),
    .done_o           (done_o),
    .victim_frame_o   (victim_frame_o),
    .outcome_o        (outcome_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial forever #2 clk_i = ~clk_i;

  // A frame count of zero scans one frame; anything above the table scans all.
  function automatic int unsigned scan_frames(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > 7'(fvs_pkg::MaxFramesDef)) return fvs_pkg::MaxFramesDef;
    return v;
  endfunction

  // Applies one accepted command word to the predicted table and queues the
  // result word that a victim request must give.
  function automatic void predict_command(logic [1:0] cmd, logic [5:0] idx, logic mv,
                                          logic pv, logic [63:0] coins);
    int unsigned n;
    int unsigned start;
    int unsigned f;
    int unsigned pick;
    int unsigned last;
    bit          found;
    bit          seen;
    victim_t     res;
    found = 1'b0;
    seen  = 1'b0;
    pick  = 0;
    last  = 0;
    case (cmd)
      fvs_pkg::CMD_REFERENCE: frame_refd[idx] = 1'b1;
      fvs_pkg::CMD_WRITE_FLAGS: begin
        frame_mapped[idx] = mv;
        frame_prot[idx]   = pv;
      end
      fvs_pkg::CMD_VICTIM: begin
        n = scan_frames(frames_reg);
        // A free frame wins and leaves the hand and all flags alone.
        for (int i = 0; i < n; i++) begin
          if (!found && !frame_prot[i] && !frame_mapped[i]) begin
            found = 1'b1;
            pick  = i;
          end
        end
        if (found) begin
          res.frame   = 6'(pick);
          res.outcome = fvs_pkg::OUT_FREE;
        end else begin
          start = sweep_hand % n;
          case (mode_reg)
            fvs_pkg::POL_RANDOM: begin
              for (int i = 0; i < n; i++) begin
                if (!found && !frame_prot[i]) begin
                  seen = 1'b1;
                  last = i;
                  if (coins[i]) begin
                    found = 1'b1;
                    pick  = i;
                  end
                end
              end
              if (!found && seen) begin
                found = 1'b1;
                pick  = last;
              end
            end
            fvs_pkg::POL_FIFO: begin
              for (int i = 0; i < n; i++) begin
                f = (start + i) % n;
                if (!found && !frame_prot[f]) begin
                  found      = 1'b1;
                  pick       = f;
                  sweep_hand = (f + 1) % n;
                end
              end
            end
            fvs_pkg::POL_CLOCK: begin
              // Two rounds at most; referenced frames lose their bit as the hand passes.
              for (int i = 0; i < 2 * n; i++) begin
                f = (start + i) % n;
                if (!found && !frame_prot[f]) begin
                  if (frame_refd[f]) begin
                    frame_refd[f] = 1'b0;
                  end else begin
                    found      = 1'b1;
                    pick       = f;
                    sweep_hand = (f + 1) % n;
                  end
                end
              end
            end
            default: ;
          endcase
          if (found) begin
            frame_mapped[pick] = 1'b0;
            res.frame   = 6'(pick);
            res.outcome = fvs_pkg::OUT_EVICT;
          end else begin
            res.frame   = 6'd0;
            res.outcome = fvs_pkg::OUT_ALL_PROT;
          end
        end
        owed_victims.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand_coins();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void add_cmd(logic [1:0] cmd, logic [5:0] idx, logic mv, logic pv,
                                  logic [63:0] coins);
    stim_t s;
    s          = '0;
    s.kind     = SK_CMD;
    s.cmd      = cmd;
    s.idx      = idx;
    s.map_val  = mv;
    s.prot_val = pv;
    s.coins    = coins;
    stim_q.push_back(s);
  endfunction

  function automatic void add_cfg(fvs_pkg::cfg_reg_e sel, logic [6:0] val);
    stim_t s;
    s         = '0;
    s.kind    = SK_CFG;
    s.reg_sel = sel;
    s.wdata   = val;
    stim_q.push_back(s);
  endfunction

  // Mostly frames inside the scanned range, with some noise and unused commands.
  function automatic void add_random_cmd(int unsigned n_eff);
    int unsigned choice;
    logic [5:0]  idx;
    choice = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) idx = 6'($urandom_range(0, 63));
    else idx = 6'($urandom_range(0, n_eff - 1));
    if (choice < 35)
      add_cmd(fvs_pkg::CMD_VICTIM, 6'($urandom), 1'($urandom), 1'($urandom), rand_coins());
    else if (choice < 55)
      add_cmd(fvs_pkg::CMD_REFERENCE, idx, 1'($urandom), 1'($urandom), rand_coins());
    else if (choice < 95)
      add_cmd(fvs_pkg::CMD_WRITE_FLAGS, idx, 1'($urandom_range(0, 7) != 0),
              1'($urandom_range(0, 6) == 0), rand_coins());
    else
      add_cmd(CmdUnused, 6'($urandom), 1'($urandom), 1'($urandom), rand_coins());
  endfunction

  // Driver: sends command words in bursts, and writes registers only once the
  // block has been quiet for a full worst-case request.
  always @(posedge clk_i) begin : driver
    logic  hold;
    logic  we;
    stim_t s;
    if (rst_ni) begin
      hold = start_i;
      we   = 1'b0;
      if (start_i && !busy_o) begin
        hold = 1'b0;
        if (command_i == fvs_pkg::CMD_VICTIM) results_owed = results_owed + 1;
      end
      if (done_o) results_owed = results_owed - 1;
      if (results_owed == 0 && !start_i && !busy_o) quiet_cycles = quiet_cycles + 1;
      else quiet_cycles = 0;
      if (!hold && stim_q.size() > 0) begin
        s = stim_q[0];
        case (s.kind)
          SK_CMD: begin
            if (gap_left > 0) begin
              gap_left = gap_left - 1;
            end else begin
              command_i         <= s.cmd;
              frame_index_i     <= s.idx;
              mapped_value_i    <= s.map_val;
              protected_value_i <= s.prot_val;
              coin_bits_i       <= s.coins;
              hold = 1'b1;
              void'(stim_q.pop_front());
              burst_left = burst_left - 1;
              if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
              end
            end
          end
          SK_DRAIN: begin
            if (results_owed == 0) void'(stim_q.pop_front());
          end
          SK_CFG: begin
            if (results_owed == 0 && quiet_cycles >= DrainCycles) begin
              cfg_idx_i   <= s.reg_sel;
              cfg_wdata_i <= s.wdata;
              we = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          default: ;
        endcase
      end
      start_i  <= hold;
      cfg_we_i <= we;
    end
  end

  // Monitor: checks each result word against the oldest prediction, then
  // tracks register writes and accepted command words.
  always @(posedge clk_i) begin : monitor
    victim_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (owed_victims.size() == 0) begin
          $display("%0t: unexpected result word: victim_frame %0d outcome %0d",
                   $time, victim_frame_o, outcome_o);
          errors = errors + 1;
        end else begin
          want = owed_victims.pop_front();
          if (victim_frame_o !== want.frame) begin
            $display("%0t: victim_frame mismatch: expected %0d, actual %0d",
                     $time, want.frame, victim_frame_o);
            errors = errors + 1;
          end
          if (outcome_o !== want.outcome) begin
            $display("%0t: outcome mismatch: expected %0d, actual %0d",
                     $time, want.outcome, outcome_o);
            errors = errors + 1;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == fvs_pkg::REG_POLICY) mode_reg = cfg_wdata_i[1:0];
        else frames_reg = cfg_wdata_i;
      end
      if (start_i && !busy_o)
        predict_command(command_i, frame_index_i, mapped_value_i, protected_value_i,
                        coin_bits_i);
      if ((start_i && !busy_o) || done_o || cfg_we_i) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= StallLimit) stalled = 1'b1;
    end
  end

  initial begin : main
    logic [1:0]  pol;
    logic [6:0]  fr;
    int unsigned n_eff;
    int          tail;
    stim_t       pause;

    // Directed: free frames, the coin extremes and an unused command.
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd0, 1'b0, 1'b0, '1);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd63, 1'b1, 1'b1, 64'd0);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd0, 1'b1, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_REFERENCE, 6'd0, 1'b0, 1'b0, 64'd0);
    add_cmd(CmdUnused, 6'd0, 1'b1, 1'b1, '1);
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd63, 1'b1, 1'b1, '1);
    // A frame count of zero: no coin falls back to the last unprotected frame,
    // then the only frame is protected.
    add_cfg(fvs_pkg::REG_POLICY, {5'd0, fvs_pkg::POL_RANDOM});
    add_cfg(fvs_pkg::REG_FRAMES, 7'd0);
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd0, 1'b0, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd0, 1'b1, 1'b1, 64'd0);
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd0, 1'b0, 1'b0, 64'd0);
    // FIFO over three full frames moves the hand to frame 2.
    add_cfg(fvs_pkg::REG_POLICY, {5'd0, fvs_pkg::POL_FIFO});
    add_cfg(fvs_pkg::REG_FRAMES, 7'd3);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd0, 1'b1, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd1, 1'b1, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd2, 1'b1, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd0, 1'b0, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd0, 1'b1, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd0, 1'b0, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd1, 1'b1, 1'b0, 64'd0);
    // Clock sweep over two frames with the hand beyond the count; both frames
    // are referenced, so the pick comes in the second round.
    add_cfg(fvs_pkg::REG_POLICY, {5'd0, fvs_pkg::POL_CLOCK});
    add_cfg(fvs_pkg::REG_FRAMES, 7'd2);
    add_cmd(fvs_pkg::CMD_REFERENCE, 6'd0, 1'b0, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_REFERENCE, 6'd1, 1'b0, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd0, 1'b0, 1'b0, 64'd0);
    // Unused policy with a frame count above the table, then with no free frame.
    add_cfg(fvs_pkg::REG_POLICY, {5'd0, PolicyUnused});
    add_cfg(fvs_pkg::REG_FRAMES, 7'd127);
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd0, 1'b0, 1'b0, '1);
    add_cfg(fvs_pkg::REG_FRAMES, 7'd1);
    add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'd0, 1'b1, 1'b0, 64'd0);
    add_cmd(fvs_pkg::CMD_VICTIM, 6'd0, 1'b0, 1'b0, '1);

    // Random phases: each maps every scanned frame first so that evictions and
    // sweeps are reached, then mixes requests, references and flag writes.
    for (int p = 0; p < NumPhases; p++) begin
      pol = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 11))
        0: fr = 7'd0;
        1: fr = 7'd127;
        2: fr = 7'd64;
        3: fr = 7'd1;
        default: fr = 7'($urandom_range(2, 8));
      endcase
      add_cfg(fvs_pkg::REG_POLICY, {5'd0, pol});
      add_cfg(fvs_pkg::REG_FRAMES, fr);
      n_eff = scan_frames(fr);
      for (int f = 0; f < n_eff; f++)
        add_cmd(fvs_pkg::CMD_WRITE_FLAGS, 6'(f), 1'b1, 1'($urandom_range(0, 5) == 0),
                rand_coins());
      for (int k = 0; k < PhaseItems; k++) begin
        // Now and then hold the next word back until every result is in.
        if (k == PhaseItems / 2 && $urandom_range(0, 1) == 1) begin
          pause      = '0;
          pause.kind = SK_DRAIN;
          stim_q.push_back(pause);
        end
        add_random_cmd(n_eff);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the queue to empty and the block to stay quiet for a full request.
    tail = 0;
    while (tail < DrainCycles && !stalled) begin
      @(negedge clk_i);
      if (stim_q.size() == 0 && !start_i && !busy_o && results_owed == 0) tail = tail + 1;
      else tail = 0;
    end

    if (stalled) begin
      $display("%0t: no word accepted for %0d cycles", $time, StallLimit);
      $display("status: fail");
    end else begin
      if (owed_victims.size() != 0) begin
        $display("%0t: %0d expected result words never arrived", $time,
                 owed_victims.size());
        errors = errors + 1;
      end
      if (errors == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule
